[design/hwt_pkg.sv]
// ----------------------------------------------------------------------------
// hwt_pkg: heartbeat watchdog table package
// Types, codes and sizing constants shared by the watchdog table modules.
// ----------------------------------------------------------------------------
package hwt_pkg;

   localparam int MONITOR_SLOTS = 8;
   localparam int SLOT_IDX_W    = (MONITOR_SLOTS > 1) ? $clog2(MONITOR_SLOTS) : 1;
   localparam int SLOT_CNT_W    = $clog2(MONITOR_SLOTS + 1);

   localparam logic [1:0] MODE_REGISTER  = 2'd0;
   localparam logic [1:0] MODE_HEARTBEAT = 2'd1;
   localparam logic [1:0] MODE_CHECK     = 2'd2;

   typedef enum logic [1:0] {
      OP_REGISTER  = 2'd0,
      OP_HEARTBEAT = 2'd1,
      OP_CHECK     = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  source_id;
      logic [31:0] time_value;
      logic [31:0] timeout_length;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  failed_source;
      logic [31:0] last_seen;
      logic [31:0] timeout_used;
      logic        last_of_run;
   } rsp_item_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  source_id;
      logic [31:0] time_value;
      logic [31:0] timeout_length;
   } cmd_type;

   typedef struct packed {
      logic [SLOT_CNT_W-1:0] used;
      logic                  idle;
   } back_status_type;

endpackage

[design/hwt_if.sv]
// ----------------------------------------------------------------------------
// hwt_if: heartbeat watchdog table channels
// Valid/ready channels for request items and timeout result items.
// ----------------------------------------------------------------------------
interface hwt_req_if import hwt_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hwt_rsp_if import hwt_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[design/hwt_front.sv]
// ----------------------------------------------------------------------------
// hwt_front: request intake
// Accepts request items, decodes the mode and registers one command.
// ----------------------------------------------------------------------------
module hwt_front import hwt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hwt_req_if.sink    req_ch,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_ready
);

   logic    fe_valid_ff, fe_valid_in;
   cmd_type fe_cmd_ff, fe_cmd_in;
   logic    accept;
   logic    mode_ok;
   op_type  op_dec;

   assign req_ch.ready = !fe_valid_ff || cmd_ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign cmd_valid    = fe_valid_ff;
   assign cmd          = fe_cmd_ff;

   always_comb begin
      mode_ok = 1'b1;
      op_dec  = OP_REGISTER;
      unique case (req_ch.payload.mode)
         MODE_REGISTER:  op_dec = OP_REGISTER;
         MODE_HEARTBEAT: op_dec = OP_HEARTBEAT;
         MODE_CHECK:     op_dec = OP_CHECK;
         default:        mode_ok = 1'b0;
      endcase
   end

   always_comb begin
      fe_valid_in = fe_valid_ff;
      fe_cmd_in   = fe_cmd_ff;
      if (fe_valid_ff && cmd_ready) begin
         fe_valid_in = 1'b0;
      end
      // drop items with an unused mode
      if (accept) begin
         fe_valid_in              = mode_ok;
         fe_cmd_in.op             = op_dec;
         fe_cmd_in.source_id      = req_ch.payload.source_id;
         fe_cmd_in.time_value     = req_ch.payload.time_value;
         fe_cmd_in.timeout_length = req_ch.payload.timeout_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fe_valid_ff <= 1'b0;
      end else begin
         fe_valid_ff <= fe_valid_in;
      end
      fe_cmd_ff <= fe_cmd_in;
   end

endmodule

[design/hwt_queue.sv]
// ----------------------------------------------------------------------------
// hwt_queue: command queue
// Two-entry queue of decoded commands between intake and table engine.
// ----------------------------------------------------------------------------
module hwt_queue import hwt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop
);

   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   cmd_type             q_mem [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = q_mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/hwt_back.sv]
// ----------------------------------------------------------------------------
// hwt_back: table engine
// Holds the slot table, runs register, heartbeat search and timeout scan,
// and drives the result register.
// ----------------------------------------------------------------------------
module hwt_back import hwt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  cmd_type         q_cmd,
   output logic            q_pop,
   hwt_rsp_if.source       rsp_ch,
   output back_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   logic [7:0]  slot_src_mem [MONITOR_SLOTS];
   logic [31:0] slot_ls_mem  [MONITOR_SLOTS];
   logic [31:0] slot_tmo_mem [MONITOR_SLOTS];

   state_type             state_ff, state_in;
   cmd_type               cur_ff, cur_in;
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic [SLOT_CNT_W-1:0] used_ff, used_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_item_type          pend_ff, pend_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_item_type          out_ff, out_in;
   logic [7:0]            rd_src_ff;
   logic [31:0]           rd_ls_ff;
   logic [31:0]           rd_tmo_ff;

   logic                  wr_slot;
   logic                  wr_hb;
   logic                  out_free;
   logic                  last_slot;
   logic                  timed_out;
   logic [31:0]           elapsed;
   rsp_item_type          new_res;

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_ff;
   assign status.used    = used_ff;
   assign status.idle    = (state_ff == ST_IDLE);

   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign last_slot = ((SLOT_CNT_W'(idx_ff) + SLOT_CNT_W'(1)) == used_ff);
   assign elapsed   = cur_ff.time_value - rd_ls_ff;
   assign timed_out = (elapsed > rd_tmo_ff);

   always_comb begin
      new_res.failed_source = rd_src_ff;
      new_res.last_seen     = rd_ls_ff;
      new_res.timeout_used  = rd_tmo_ff;
      new_res.last_of_run   = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      q_pop         = 1'b0;
      wr_slot       = 1'b0;
      wr_hb         = 1'b0;

      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_cmd;
               idx_in = '0;
               unique case (q_cmd.op)
                  OP_REGISTER: begin
                     if (used_ff < SLOT_CNT_W'(MONITOR_SLOTS)) begin
                        wr_slot = 1'b1;
                        used_in = used_ff + SLOT_CNT_W'(1);
                     end
                  end
                  OP_HEARTBEAT, OP_CHECK: begin
                     if (used_ff != '0) begin
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            unique case (cur_ff.op)
               OP_HEARTBEAT: begin
                  if (rd_src_ff == cur_ff.source_id) begin
                     wr_hb    = 1'b1;
                     state_in = ST_IDLE;
                  end else if (last_slot) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in   = idx_ff + SLOT_IDX_W'(1);
                     state_in = ST_READ;
                  end
               end
               OP_CHECK: begin
                  // hold while a pending result cannot move to the output
                  if (!(timed_out && pend_valid_ff && !out_free)) begin
                     if (timed_out) begin
                        if (pend_valid_ff) begin
                           out_in       = pend_ff;
                           out_valid_in = 1'b1;
                        end
                        pend_in       = new_res;
                        pend_valid_in = 1'b1;
                     end
                     if (last_slot) begin
                        state_in = ST_FLUSH;
                     end else begin
                        idx_in   = idx_ff + SLOT_IDX_W'(1);
                        state_in = ST_READ;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in             = pend_ff;
               out_in.last_of_run = 1'b1;
               out_valid_in       = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_slot) begin
         slot_src_mem[used_ff[SLOT_IDX_W-1:0]] <= q_cmd.source_id;
         slot_ls_mem[used_ff[SLOT_IDX_W-1:0]]  <= q_cmd.time_value;
         slot_tmo_mem[used_ff[SLOT_IDX_W-1:0]] <= q_cmd.timeout_length;
      end else if (wr_hb) begin
         slot_ls_mem[idx_ff] <= cur_ff.time_value;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_src_ff <= slot_src_mem[idx_ff];
         rd_ls_ff  <= slot_ls_mem[idx_ff];
         rd_tmo_ff <= slot_tmo_mem[idx_ff];
      end
   end

endmodule

[design/heartbeat_watchdog_table.sv]
// ----------------------------------------------------------------------------
// heartbeat_watchdog_table: multi-source heartbeat watchdog
// Keeps a table of monitored sources and reports those that went silent.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries request items: mode 0 registers a source with its timeout,
//   mode 1 refreshes the last-seen time of the first slot with that id,
//   mode 2 checks every filled slot against the given current time. Mode 3
//   items are taken and dropped.
//   rsp_ch carries one item per timed-out slot of a check, in slot order;
//   the final item of a check has last_of_run set. A check with no timeout
//   gives no item.
//   Flow: an item passes the intake register and a two-entry queue, then
//   the table engine reads each slot from its slot memory in a read state
//   and weighs it in an evaluate state. A register item is written from the
//   idle state; a heartbeat or check visits the filled slots in order. A
//   result waits in a pending register until the next timed-out slot is
//   found or the scan ends.
//   Reset empties the table, the queue and the result register.
//   When rsp_ch stalls, the engine holds mid-scan once a timed-out slot finds
//   the result and pending registers full; intake takes items until the
//   queue and the intake register fill.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_table import hwt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hwt_req_if.sink   req_ch,
   hwt_rsp_if.source rsp_ch
);

   logic            fe_valid;
   cmd_type         fe_cmd;
   logic            fe_ready;
   logic            q_valid;
   cmd_type         q_cmd;
   logic            q_pop;
   back_status_type be_status;

   hwt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (fe_valid),
      .cmd       (fe_cmd),
      .cmd_ready (fe_ready)
   );

   hwt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_valid),
      .push_cmd   (fe_cmd),
      .push_ready (fe_ready),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd),
      .pop        (q_pop)
   );

   hwt_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch),
      .status  (be_status)
   );

`ifndef ASSERT_OFF
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      be_status.used <= SLOT_CNT_W'(MONITOR_SLOTS))
      else $error("slot count beyond table size");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (be_status.used == $past(be_status.used)) ||
                        (be_status.used == $past(be_status.used) + SLOT_CNT_W'(1)))
      else $error("slot count moved by other than one");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid && be_status.idle)
      else $error("queue popped while empty or engine busy");
`endif

endmodule
